### design/hrf_pkg.sv
// Shared types and constants for the HID report framer.
// No dependencies.
package hrf_pkg;

   localparam int REPORT_BYTES_DEF = 64;
   localparam int QUEUE_DEPTH      = 2;

   localparam logic [1:0] REQ_START    = 2'd0;
   localparam logic [1:0] REQ_DATA     = 2'd1;
   localparam logic [1:0] REQ_FLUSH    = 2'd2;
   localparam logic [1:0] REQ_RESERVED = 2'd3;

   // header byte indexes
   localparam logic [2:0] HDR_CMD_SEQ    = 3'd4;
   localparam logic [2:0] HDR_COUNT_HI   = 3'd5;
   localparam logic [2:0] FIRST_HDR_LAST = 3'd6;
   localparam logic [2:0] NEXT_HDR_LAST  = 3'd4;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] channel_id;
      logic [7:0]  command;
      logic [15:0] byte_count;
      logic [7:0]  data_byte;
   } cmd_type;

endpackage

### design/hrf_if.sv
// Request and response channel interfaces of the HID report framer.
// No dependencies.
interface hrf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] channel_id;
   logic [7:0]  command;
   logic [15:0] byte_count;
   logic [7:0]  data_byte;

   modport source (output valid, req_type, channel_id, command, byte_count, data_byte,
                   input ready);
   modport sink (input valid, req_type, channel_id, command, byte_count, data_byte,
                 output ready);
endinterface

interface hrf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] report_byte;
   logic       report_last;

   modport source (output valid, report_byte, report_last, input ready);
   modport sink (input valid, report_byte, report_last, output ready);
endinterface

### design/hid_report_framer.sv
// A report goes out when a data byte fills it or on a flush; a flush of an empty message sends
// a report that holds only the header. The sequencer takes a new command only while idle.
// Each report opens with a header: 7 bytes in the first report of a message, 5 in later ones;
// a report then streams out REPORT_BYTES bytes, one byte per cycle unless rsp.ready stalls it.
// A 2-entry command queue takes commands while a report streams out, until it is full.
// Reset: synchronous, clears queue, sequencer and output valid; the store is not cleared.
module hid_report_framer import hrf_pkg::*; #(
   parameter int REPORT_BYTES = REPORT_BYTES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   hrf_req_if.sink   req,
   hrf_rsp_if.source rsp
);

   logic    push_valid, push_ready;
   cmd_type push_cmd;
   logic    pop_valid, pop_ready;
   cmd_type pop_cmd;

   hrf_front u_front (
      .req        (req),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   hrf_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   hrf_back #(
      .REPORT_BYTES (REPORT_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .rsp       (rsp)
   );

endmodule

### design/hrf_front.sv
// Front end: accepts request words, drops unused selectors, builds commands.
// Depends on hrf_pkg and hrf_req_if.
module hrf_front import hrf_pkg::*; (
   hrf_req_if.sink   req,
   output logic      push_valid,
   input  logic      push_ready,
   output cmd_type   push_cmd
);

   assign req.ready  = push_ready;
   assign push_valid = req.valid && (req.req_type != REQ_RESERVED);

   always_comb begin
      push_cmd.op         = req.req_type;
      push_cmd.channel_id = req.channel_id;
      push_cmd.command    = req.command;
      push_cmd.byte_count = req.byte_count;
      push_cmd.data_byte  = req.data_byte;
   end

endmodule

### design/hrf_cmd_queue.sv
// Short command queue between front end and report sequencer.
// Depends on hrf_pkg.
module hrf_cmd_queue import hrf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   cmd_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### design/hrf_back.sv
// Back end: header sequencer, report store and report output pipeline.
// Depends on hrf_pkg and hrf_rsp_if.
module hrf_back import hrf_pkg::*; #(
   parameter int REPORT_BYTES = REPORT_BYTES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      pop_valid,
   output logic      pop_ready,
   input  cmd_type   pop_cmd,
   hrf_rsp_if.source rsp
);

   localparam int ADDR_W = $clog2(REPORT_BYTES);
   localparam int FILL_W = $clog2(REPORT_BYTES + 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(REPORT_BYTES);
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(REPORT_BYTES - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_HDR  = 2'd1;
   localparam logic [1:0] ST_DATA = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [7:0]        store_mem [REPORT_BYTES];

   logic [1:0]        state_ff, state_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              any_ff, any_in;
   logic [7:0]        seq_ff, seq_in;
   logic [31:0]       chan_ff, chan_in;
   logic [7:0]        cmd_ff, cmd_in;
   logic [15:0]       count_ff, count_in;
   logic [7:0]        byte_ff, byte_in;
   logic [2:0]        hdr_idx_ff, hdr_idx_in;
   logic              hdr_first_ff, hdr_first_in;
   logic              flush_ff, flush_in;
   logic [FILL_W-1:0] emit_fill_ff, emit_fill_in;
   logic [ADDR_W-1:0] emit_idx_ff, emit_idx_in;

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_zero_ff;
   logic              s1_last_ff;
   logic [7:0]        rd_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff;
   logic              rsp_last_ff;

   logic [FILL_W-1:0] fill_inc;
   logic [7:0]        hdr_byte;
   logic              hdr_done;
   logic              wr_en;
   logic [7:0]        wr_data;
   logic              out_free, s1_adv, s1_free, issue;

   assign pop_ready = (state_ff == ST_IDLE);
   assign fill_inc  = fill_ff + 1'b1;
   assign hdr_done  = (hdr_idx_ff == (hdr_first_ff ? FIRST_HDR_LAST : NEXT_HDR_LAST));

   always_comb begin
      case (hdr_idx_ff)
         3'd0:         hdr_byte = chan_ff[7:0];
         3'd1:         hdr_byte = chan_ff[15:8];
         3'd2:         hdr_byte = chan_ff[23:16];
         3'd3:         hdr_byte = chan_ff[31:24];
         HDR_CMD_SEQ:  hdr_byte = hdr_first_ff ? cmd_ff : seq_ff;
         HDR_COUNT_HI: hdr_byte = count_ff[15:8];
         default:      hdr_byte = count_ff[7:0];
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign s1_adv   = s1_valid_ff && out_free;
   assign s1_free  = !s1_valid_ff || out_free;
   assign issue    = (state_ff == ST_EMIT) && s1_free;

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      any_in       = any_ff;
      seq_in       = seq_ff;
      chan_in      = chan_ff;
      cmd_in       = cmd_ff;
      count_in     = count_ff;
      byte_in      = byte_ff;
      hdr_idx_in   = hdr_idx_ff;
      hdr_first_in = hdr_first_ff;
      flush_in     = flush_ff;
      emit_fill_in = emit_fill_ff;
      emit_idx_in  = emit_idx_ff;
      wr_en        = 1'b0;
      wr_data      = byte_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               case (pop_cmd.op)
                  REQ_START: begin
                     chan_in  = pop_cmd.channel_id;
                     cmd_in   = pop_cmd.command;
                     count_in = pop_cmd.byte_count;
                     fill_in  = '0;
                     any_in   = 1'b0;
                     seq_in   = '0;
                  end
                  REQ_DATA: begin
                     byte_in = pop_cmd.data_byte;
                     if (fill_ff == '0) begin
                        hdr_idx_in   = '0;
                        hdr_first_in = !any_ff;
                        flush_in     = 1'b0;
                        state_in     = ST_HDR;
                     end else begin
                        state_in = ST_DATA;
                     end
                  end
                  REQ_FLUSH: begin
                     if (fill_ff == '0 && !any_ff) begin
                        hdr_idx_in   = '0;
                        hdr_first_in = 1'b1;
                        flush_in     = 1'b1;
                        state_in     = ST_HDR;
                     end else if (fill_ff != '0) begin
                        emit_fill_in = fill_ff;
                        emit_idx_in  = '0;
                        state_in     = ST_EMIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_HDR: begin
            wr_en      = 1'b1;
            wr_data    = hdr_byte;
            fill_in    = fill_inc;
            hdr_idx_in = hdr_idx_ff + 1'b1;
            if (hdr_done) begin
               if (!hdr_first_ff) begin
                  seq_in = seq_ff + 1'b1;
               end
               if (flush_ff) begin
                  emit_fill_in = fill_inc;
                  emit_idx_in  = '0;
                  state_in     = ST_EMIT;
               end else begin
                  state_in = ST_DATA;
               end
            end
         end
         ST_DATA: begin
            wr_en   = 1'b1;
            wr_data = byte_ff;
            any_in  = 1'b1;
            if (fill_inc == FILL_FULL) begin
               fill_in      = '0;
               emit_fill_in = FILL_FULL;
               emit_idx_in  = '0;
               state_in     = ST_EMIT;
            end else begin
               fill_in  = fill_inc;
               state_in = ST_IDLE;
            end
         end
         default: begin
            if (issue) begin
               emit_idx_in = emit_idx_ff + 1'b1;
               if (emit_idx_ff == ADDR_LAST) begin
                  state_in = ST_IDLE;
               end
            end
         end
      endcase
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (issue) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         any_ff       <= 1'b0;
         seq_ff       <= '0;
         chan_ff      <= '0;
         cmd_ff       <= '0;
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         any_ff       <= any_in;
         seq_ff       <= seq_in;
         chan_ff      <= chan_in;
         cmd_ff       <= cmd_in;
         count_ff     <= count_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      hdr_idx_ff   <= hdr_idx_in;
      hdr_first_ff <= hdr_first_in;
      flush_ff     <= flush_in;
      emit_fill_ff <= emit_fill_in;
      emit_idx_ff  <= emit_idx_in;
      if (issue) begin
         s1_zero_ff <= (FILL_W'(emit_idx_ff) >= emit_fill_ff);
         s1_last_ff <= (emit_idx_ff == ADDR_LAST);
      end
      if (s1_adv) begin
         rsp_byte_ff <= s1_zero_ff ? 8'h00 : rd_data_ff;
         rsp_last_ff <= s1_last_ff;
      end
   end

   // report store; bytes past the fill position are sent as zero padding by the output pipeline
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[fill_ff[ADDR_W-1:0]] <= wr_data;
      end
      if (issue) begin
         rd_data_ff <= store_mem[emit_idx_ff];
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.report_byte = rsp_byte_ff;
   assign rsp.report_last = rsp_last_ff;

endmodule
